### hdl/dpod_pkg.sv
package dpod_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 22;
  // day numbers reach about 6e6 for year 16383
  localparam int DNUM_W  = 23;
  localparam int MULK_W  = 13;
  localparam int PROD_W  = YEAR_W + MULK_W;
  localparam int CENT_W  = 8;
  localparam int CUM_W   = 9;

  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [DNUM_W-1:0]  dnum_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [MULK_W-1:0]  mulk_t;

  // floor(y / 100) as (y * RECIP100) >> RECIP_SHIFT, exact for 14-bit years
  localparam mulk_t RECIP100    = 13'd5243;
  localparam int    RECIP_SHIFT = 19;
  localparam mulk_t YEAR_DAYS   = 13'd365;
  localparam month_t FEB        = 4'd2;
  localparam month_t DEC        = 4'd12;
  localparam day_t   FEB_LEAP   = 5'd29;
  localparam count_t COUNT_MAX  = '1;

  localparam day_t MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [CUM_W-1:0] DAYS_BEFORE [12] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    year_t  first_start_year;
    month_t first_start_month;
    day_t   first_start_day;
    year_t  first_end_year;
    month_t first_end_month;
    day_t   first_end_day;
    year_t  second_start_year;
    month_t second_start_month;
    day_t   second_start_day;
    year_t  second_end_year;
    month_t second_end_month;
    day_t   second_end_day;
  } dates_t;

  typedef struct packed {
    count_t shared_days;
    logic   invalid_date;
  } result_t;

  typedef struct packed {
    year_t  year;
    month_t month;
    day_t   day;
  } date_t;

  // one date takes these eight steps on the shared unit
  typedef enum logic [2:0] {
    STEP_RECIP,
    STEP_YEAR,
    STEP_LOAD,
    STEP_QUAD,
    STEP_CENT,
    STEP_QCENT,
    STEP_MONTH,
    STEP_DAY
  } step_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_BOUND,
    ST_COUNT
  } state_t;

  typedef struct packed {
    logic  run;
    step_t step;
  } unit_ctl_t;

  function automatic day_t month_length(month_t m, logic leap);
    logic [3:0] idx;
    idx = 4'(m - 4'd1);
    if (m == '0 || m > DEC) begin
      return '0;
    end
    if (m == FEB && leap) begin
      return FEB_LEAP;
    end
    return MONTH_LEN[idx];
  endfunction

  function automatic logic [CUM_W-1:0] days_before(month_t m, logic leap);
    logic [3:0] idx;
    idx = 4'(m - 4'd1);
    if (m == '0 || m > DEC) begin
      return '0;
    end
    return DAYS_BEFORE[idx] + CUM_W'(leap && m > FEB);
  endfunction

endpackage

### hdl/dpod_chan_if.sv
interface dpod_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/dpod_day_unit.sv
module dpod_day_unit (
  input  logic              clk,
  input  dpod_pkg::unit_ctl_t ctl,
  input  dpod_pkg::date_t   date,
  output dpod_pkg::dnum_t   dnum,
  output logic              ok
);
  import dpod_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [CENT_W-1:0] cent;
  dnum_t             acc;

  mulk_t             mul_k;
  year_t             cent_x100;
  year_t             rem;
  logic              rem_nz;
  logic              leap;
  logic [YEAR_W-2:0] c4;
  logic [CENT_W-1:0] c100;
  logic [CENT_W-3:0] c400;
  dnum_t             term;
  dnum_t             opa;
  logic              sub;
  dnum_t             sum;

  // shared multiplier: reciprocal of 100 first, then days per year
  assign mul_k = (ctl.step == STEP_RECIP) ? RECIP100 : YEAR_DAYS;

  // year split into centuries and remainder
  assign cent_x100 = YEAR_W'({cent, 6'b0}) + YEAR_W'({cent, 5'b0}) + YEAR_W'({cent, 2'b0});
  assign rem       = date.year - cent_x100;
  assign rem_nz    = |rem;
  assign leap      = (date.year[1:0] == 2'b00) && (rem_nz || cent[1:0] == 2'b00);

  // ceil(y/4), ceil(y/100), ceil(y/400)
  assign c4   = date.year[YEAR_W-1:2] + (YEAR_W-1)'(date.year[1:0] != 2'b00);
  assign c100 = cent + CENT_W'(rem_nz);
  assign c400 = cent[CENT_W-1:2] + (CENT_W-2)'(cent[1:0] != 2'b00 || rem_nz);

  assign ok = (date.day != '0) && (date.day <= month_length(date.month, leap));

  always_comb begin
    term = '0;
    sub  = 1'b0;
    unique case (ctl.step)
      STEP_RECIP: term = '0;
      STEP_YEAR:  term = '0;
      STEP_LOAD:  term = prod[DNUM_W-1:0];
      STEP_QUAD:  term = DNUM_W'(c4);
      STEP_CENT: begin
        term = DNUM_W'(c100);
        sub  = 1'b1;
      end
      STEP_QCENT: term = DNUM_W'(c400);
      STEP_MONTH: term = DNUM_W'(days_before(date.month, leap));
      STEP_DAY:   term = DNUM_W'(DAY_W'(date.day - 5'd1));
      default:    term = '0;
    endcase
  end

  // shared adder
  assign opa  = (ctl.step == STEP_LOAD) ? '0 : acc;
  assign sum  = opa + (sub ? ~term : term) + DNUM_W'(sub);
  assign dnum = sum;

  always_ff @(posedge clk) begin
    if (ctl.run) begin
      prod <= PROD_W'(date.year) * PROD_W'(mul_k);
      if (ctl.step == STEP_YEAR) begin
        cent <= prod[RECIP_SHIFT +: CENT_W];
      end
      if (ctl.step != STEP_RECIP && ctl.step != STEP_YEAR) begin
        acc <= sum;
      end
    end
  end

endmodule

### hdl/date_period_overlap_days.sv
// channel  | dir | payload                         | handshake
// ---------+-----+---------------------------------+-------------------
// dates    | in  | two periods, four y/m/d dates   | valid/ready
// result   | out | shared_days, invalid_date       | valid/ready
//
// an item runs from acceptance until its result is loaded through the
// 8 steps on the shared multiplier/adder for each of the four dates, the
// bound state to pick the later start and earlier end, and the count state
// to form the count; dates.ready is high only while the sequencer is idle
// a finished result sits in the output register; if it is still unclaimed
// when the next count is ready, the sequencer holds until result.ready
// rst (synchronous) clears the sequencer and the output valid
module date_period_overlap_days (
  input logic        clk,
  input logic        rst,
  dpod_chan_if.sink   dates,
  dpod_chan_if.source result
);
  import dpod_pkg::*;

  state_t    state;
  state_t    state_next;
  step_t     step;
  logic [1:0] idx;
  dates_t    item;
  dnum_t     n [4];
  logic      bad;
  dnum_t     lo;
  dnum_t     hi;
  result_t   out_data;
  logic      out_valid;

  unit_ctl_t ctl;
  date_t     cur;
  dnum_t     dnum;
  logic      ok;
  logic      accept;
  logic      load_out;
  logic      last_step;

  logic [DNUM_W:0] diff;
  dnum_t           cnt;
  count_t          count;

  // date presented to the shared unit
  always_comb begin
    case (idx)
      2'd0:    cur = '{item.first_start_year, item.first_start_month, item.first_start_day};
      2'd1:    cur = '{item.first_end_year, item.first_end_month, item.first_end_day};
      2'd2:    cur = '{item.second_start_year, item.second_start_month,
                       item.second_start_day};
      default: cur = '{item.second_end_year, item.second_end_month, item.second_end_day};
    endcase
  end

  dpod_day_unit u_day (
    .clk  (clk),
    .ctl  (ctl),
    .date (cur),
    .dnum (dnum),
    .ok   (ok)
  );

  assign last_step = (step == STEP_DAY) && (idx == 2'd3);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (dates.valid) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (last_step) begin
          state_next = ST_BOUND;
        end
      end
      ST_BOUND: state_next = ST_COUNT;
      ST_COUNT: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    dates.ready = 1'b0;
    ctl.run     = 1'b0;
    ctl.step    = step;
    load_out    = 1'b0;
    unique case (state)
      ST_IDLE:  dates.ready = 1'b1;
      ST_CONV:  ctl.run = 1'b1;
      ST_BOUND: ;
      ST_COUNT: load_out = !out_valid || result.ready;
      default:  ;
    endcase
  end

  assign accept = dates.valid && dates.ready;

  // overlap length, inclusive of both ends
  assign diff = {1'b0, hi} - {1'b0, lo};
  assign cnt  = diff[DNUM_W-1:0] + DNUM_W'(1);

  always_comb begin
    if (bad || diff[DNUM_W]) begin
      count = '0;
    end else if (cnt > DNUM_W'(COUNT_MAX)) begin
      count = COUNT_MAX;
    end else begin
      count = cnt[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_RECIP;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CONV) begin
        // wraps back to the first step of the first date after the last one
        step <= step_t'(step + 3'd1);
        if (step == STEP_DAY) begin
          idx <= idx + 2'd1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= dates.data;
      bad  <= 1'b0;
    end
    if (state == ST_CONV && step == STEP_DAY) begin
      n[idx] <= dnum;
      bad    <= bad | !ok;
    end
    if (state == ST_BOUND) begin
      lo <= (n[0] > n[2]) ? n[0] : n[2];
      hi <= (n[1] < n[3]) ? n[1] : n[3];
    end
    if (load_out) begin
      out_data.shared_days  <= count;
      out_data.invalid_date <= bad;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

`ifndef SYNTHESIS
  // a flagged item never reports shared days
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.invalid_date |-> result.data.shared_days == '0)
    else $error("invalid item reports nonzero shared days");

  // the sequencer reaches the bound state once the four conversions are done
  a_conv_len: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##33 state == ST_BOUND)
    else $error("date conversion length wrong");

  // step and date counters rest at zero outside conversion
  a_counters_home: assert property (@(posedge clk) disable iff (rst)
    state != ST_CONV |-> step == STEP_RECIP && idx == 2'd0)
    else $error("sequencer counters not at rest");
`endif

endmodule
